// ===== rtl/core/nbtq_pkg.sv =====
// Shared types and constants of the nearest box track qualifier.
`default_nettype none

package nbtq_pkg;

  // Coordinate and register widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIST_W   = 34;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned ACQ_W    = 8;
  localparam int unsigned REG_INDEX_W = 1;
  localparam int unsigned REG_DATA_W  = 16;

  // Register indexes of the configuration port
  localparam logic [REG_INDEX_W-1:0] REG_CHECK_WINDOW  = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_ACQUIRE_COUNT = 1'b1;

  // Item kinds carried in func
  localparam logic FUNC_BOX  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Register reset values
  localparam logic [WINDOW_W-1:0] CHECK_WINDOW_RST  = 16'd50;
  localparam logic [ACQ_W-1:0]    ACQUIRE_COUNT_RST = 8'd10;

  typedef struct packed {
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W-1:0] x;
  } box_t;

  // 320, 240 and 4 pixels in Q12.4
  localparam box_t HOME_BOX = '{u: 16'sd5120, v: 16'sd3840, x: 16'sd64};
  localparam box_t ZERO_BOX = '{u: 16'sd0, v: 16'sd0, x: 16'sd0};
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/core/nbtq_if.sv =====
// Handshake channels of the nearest box track qualifier: input items and results.
`default_nettype none

interface nbtq_item_if;
  import nbtq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic                      box_present;
  logic signed [COORD_W-1:0] box_u;
  logic signed [COORD_W-1:0] box_v;
  logic signed [COORD_W-1:0] box_extra;
  logic                      frame_last;

  modport source (
    output valid, func, box_present, box_u, box_v, box_extra, frame_last,
    input  ready
  );
  modport sink (
    input  valid, func, box_present, box_u, box_v, box_extra, frame_last,
    output ready
  );
endinterface

interface nbtq_result_if;
  import nbtq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      tracking;
  logic signed [COORD_W-1:0] track_u;
  logic signed [COORD_W-1:0] track_v;
  logic signed [COORD_W-1:0] track_extra;

  modport source (
    output valid, tracking, track_u, track_v, track_extra,
    input  ready
  );
  modport sink (
    input  valid, tracking, track_u, track_v, track_extra,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/nearest_box_track_qualifier.sv =====
// Top level of the nearest box track qualifier: box selection and track state machine.
//
// Usage: box items and check ticks arrive on the item channel (valid/ready).
// Box items of one frame are compared against the previous box by squared
// distance; the nearest is kept and becomes the current box at the word that
// carries frame_last. A tick runs the acquire/lose counters and copies the
// current box to the previous box. Each tick and each frame end yields one
// result word (tracking flag and current box); other box words yield none.
// The result is registered in the cycle that accepts its word.
// Throughput: one word per cycle while results are taken, set by the single
// result register; the distance (two 17x17 squares, a sum and a compare) and
// the counter updates all settle between the state registers and that register.
// When the receiver stalls, the result is held and the item channel takes a
// new word only once the held result is taken (or in the same cycle).
// Configuration writes (check_window, acquire_count) are taken at any edge
// with wr_en high and should be made while the block is idle.
// Reset (rst, synchronous) restores the home box (320, 240, 4 pixels),
// clears all counters and the track flag, and empties the result register.
`default_nettype none

module nearest_box_track_qualifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [nbtq_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [nbtq_pkg::REG_DATA_W-1:0]  wr_data,
  nbtq_item_if.sink                        item,
  nbtq_result_if.source                    result
);
  import nbtq_pkg::*;

  // Configuration registers
  logic [WINDOW_W-1:0] check_window;
  logic [ACQ_W-1:0]    acquire_count;

  // Block state
  box_t                prev_box, prev_box_next;
  box_t                cur_box, cur_box_next;
  box_t                cand_box, cand_box_next;
  logic [DIST_W-1:0]   best_dist_sq, best_dist_sq_next;
  logic [1:0]          boxes_in_frame, boxes_in_frame_next;
  logic                track_flag, track_flag_next;
  logic [ACQ_W-1:0]    change_count, change_count_next;
  logic [WINDOW_W-1:0] window_count, window_count_next;
  logic [WINDOW_W-1:0] loss_count, loss_count_next;

  // Result register
  logic                result_valid;
  logic                emit;

  // Datapath temporaries
  logic                      accept;
  box_t                      in_box;
  logic signed [COORD_W:0]   du, dv;
  logic signed [DIST_W-1:0]  du_sq, dv_sq;
  logic [DIST_W-1:0]         dist_sq;
  logic                      changed;
  logic [WINDOW_W-1:0]       window_inc, loss_inc;
  logic [ACQ_W-1:0]          change_inc;
  logic [1:0]                boxes_gathered;

  // Take a word whenever the result register is free or being emptied
  assign item.ready = !result_valid || result.ready;
  assign accept     = item.valid && item.ready;

  assign in_box = '{u: item.box_u, v: item.box_v, x: item.box_extra};

  // Squared distance to the previous box, exact in 34 bits
  assign du      = {item.box_u[COORD_W-1], item.box_u} - {prev_box.u[COORD_W-1], prev_box.u};
  assign dv      = {item.box_v[COORD_W-1], item.box_v} - {prev_box.v[COORD_W-1], prev_box.v};
  assign du_sq   = du * du;
  assign dv_sq   = dv * dv;
  assign dist_sq = unsigned'(du_sq) + unsigned'(dv_sq);

  assign changed    = (cur_box != prev_box);
  assign window_inc = window_count + WINDOW_W'(1);
  assign loss_inc   = loss_count + WINDOW_W'(1);

  // Next state for one accepted word
  always_comb begin
    prev_box_next       = prev_box;
    cur_box_next        = cur_box;
    cand_box_next       = cand_box;
    best_dist_sq_next   = best_dist_sq;
    boxes_in_frame_next = boxes_in_frame;
    track_flag_next     = track_flag;
    change_count_next   = change_count;
    window_count_next   = window_count;
    loss_count_next     = loss_count;
    boxes_gathered      = boxes_in_frame;
    change_inc          = '0;
    emit                = 1'b0;

    if (item.func == FUNC_TICK) begin
      emit = 1'b1;
      if (!track_flag) begin
        loss_count_next = '0;
        // Advance the acquisition window
        if (window_inc == check_window) begin
          window_count_next = '0;
          change_count_next = '0;
        end else begin
          window_count_next = window_inc;
        end
        // Count a changed box, declare the track on reaching the target
        change_inc = change_count_next + ACQ_W'(1);
        if (changed) begin
          if (change_inc == acquire_count) begin
            change_count_next = '0;
            window_count_next = '0;
            track_flag_next   = 1'b1;
          end else begin
            change_count_next = change_inc;
          end
        end
      end else if (!changed) begin
        // Count unchanged ticks, drop the track on reaching the window
        loss_count_next = loss_inc;
        if (loss_inc == check_window) begin
          track_flag_next = 1'b0;
        end
      end
      prev_box_next = cur_box;
    end else begin
      // Keep the nearest box of the frame, the first on a tie
      if (item.box_present) begin
        if (dist_sq < best_dist_sq) begin
          best_dist_sq_next = dist_sq;
          cand_box_next     = in_box;
        end
        if (boxes_in_frame != 2'd2) begin
          boxes_gathered = boxes_in_frame + 2'd1;
        end
      end
      boxes_in_frame_next = boxes_gathered;
      // Close the frame
      if (item.frame_last) begin
        emit = 1'b1;
        if (boxes_gathered != 2'd0) begin
          cur_box_next = cand_box_next;
        end
        cand_box_next       = ZERO_BOX;
        best_dist_sq_next   = DIST_MAX;
        boxes_in_frame_next = '0;
        loss_count_next     = '0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      check_window  <= CHECK_WINDOW_RST;
      acquire_count <= ACQUIRE_COUNT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CHECK_WINDOW:  check_window  <= wr_data;
        REG_ACQUIRE_COUNT: acquire_count <= wr_data[ACQ_W-1:0];
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_box       <= HOME_BOX;
      cur_box        <= HOME_BOX;
      cand_box       <= ZERO_BOX;
      best_dist_sq   <= DIST_MAX;
      boxes_in_frame <= '0;
      track_flag     <= 1'b0;
      change_count   <= '0;
      window_count   <= '0;
      loss_count     <= '0;
    end else if (accept) begin
      prev_box       <= prev_box_next;
      cur_box        <= cur_box_next;
      cand_box       <= cand_box_next;
      best_dist_sq   <= best_dist_sq_next;
      boxes_in_frame <= boxes_in_frame_next;
      track_flag     <= track_flag_next;
      change_count   <= change_count_next;
      window_count   <= window_count_next;
      loss_count     <= loss_count_next;
    end
  end

  // Result valid: load on an emitting word, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item.ready) begin
      result_valid <= accept && emit;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result.tracking    <= track_flag_next;
      result.track_u     <= cur_box_next.u;
      result.track_v     <= cur_box_next.v;
      result.track_extra <= cur_box_next.x;
    end
  end

  assign result.valid = result_valid;

endmodule

`default_nettype wire
